// ----- hw/rtl/prefixed_radix_number_parser_defines.svh -----
// ---------------------------------------------------------------------------
// Prefixed radix number parser: assertion macros
// Shared property macros for the concurrent checks in the parser modules.
// ---------------------------------------------------------------------------
`ifndef PREFIXED_RADIX_NUMBER_PARSER_DEFINES_SVH
`define PREFIXED_RADIX_NUMBER_PARSER_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define PRNP_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define PRNP_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- hw/rtl/prnp_pkg.sv -----
// ---------------------------------------------------------------------------
// Prefixed radix number parser package
// Transaction types, classified character type and character constants.
// ---------------------------------------------------------------------------
package prnp_pkg;

  // Input transaction: one character of the string.
  typedef struct packed {
    logic [7:0] char_code;
    logic       char_present;
    logic       last;
  } in_t;

  // Result transaction.
  typedef struct packed {
    logic [31:0] value_bits;
    logic        rejected;
  } out_t;

  // Meaning of a character when it is the first non-whitespace one.
  typedef enum logic [2:0] {
    PFX_NONE,
    PFX_HEX,
    PFX_BIN,
    PFX_OCT,
    PFX_NEG
  } pfx_t;

  // Character after classification, as it waits between front and back.
  typedef struct packed {
    logic       present;
    logic       last;
    logic       space;
    logic [3:0] digit;
    pfx_t       pfx;
  } cls_t;

  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_NINE   = 8'h39;
  localparam logic [7:0] CH_UP_A   = 8'h41;
  localparam logic [7:0] CH_UP_F   = 8'h46;
  localparam logic [7:0] CH_LO_A   = 8'h61;
  localparam logic [7:0] CH_LO_F   = 8'h66;
  localparam logic [7:0] CH_CASE   = 8'h20;
  localparam logic [7:0] CH_ALPHA  = 8'd55;
  localparam logic [7:0] CH_DOLLAR = 8'h24;
  localparam logic [7:0] CH_LO_X   = 8'h78;
  localparam logic [7:0] CH_PCT    = 8'h25;
  localparam logic [7:0] CH_LO_B   = 8'h62;
  localparam logic [7:0] CH_LO_O   = 8'h6F;
  localparam logic [7:0] CH_MINUS  = 8'h2D;

  // Configuration register addressing.
  localparam int unsigned CFG_ADDR_W = 3;
  localparam logic        REG_SIGNED_MODE = 1'b0;

endpackage

// ----- hw/rtl/prnp_front.sv -----
// ---------------------------------------------------------------------------
// Parser front end
// Classifies each incoming character and holds it in a two-entry queue.
// ---------------------------------------------------------------------------
`include "prefixed_radix_number_parser_defines.svh"

module prnp_front (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 signed_mode,
  input  logic                 in_push,
  output logic                 in_full,
  input  prnp_pkg::in_t        in_data,
  output logic                 q_valid,
  output prnp_pkg::cls_t       q_head,
  input  logic                 q_pop
);

  prnp_pkg::cls_t q_r [2];
  logic           wr_ptr_r, wr_ptr_nxt;
  logic           rd_ptr_r, rd_ptr_nxt;
  logic [1:0]     cnt_r, cnt_nxt;
  prnp_pkg::cls_t cls;
  logic [7:0]     up_code;
  logic           push_ok;
  logic           pop_ok;

  // Classification of the incoming character.
  always_comb begin
    cls.present = in_data.char_present;
    cls.last    = in_data.last;
    cls.space   = (in_data.char_code == prnp_pkg::CH_SPACE) ||
                  ((in_data.char_code >= prnp_pkg::CH_TAB) &&
                   (in_data.char_code <= prnp_pkg::CH_CR));
    // Lowercase hex letters fold onto uppercase.
    if ((in_data.char_code >= prnp_pkg::CH_LO_A) && (in_data.char_code <= prnp_pkg::CH_LO_F)) begin
      up_code = in_data.char_code - prnp_pkg::CH_CASE;
    end else begin
      up_code = in_data.char_code;
    end
    if ((up_code >= prnp_pkg::CH_ZERO) && (up_code <= prnp_pkg::CH_NINE)) begin
      cls.digit = 4'(up_code - prnp_pkg::CH_ZERO);
    end else if ((up_code >= prnp_pkg::CH_UP_A) && (up_code <= prnp_pkg::CH_UP_F)) begin
      cls.digit = 4'(up_code - prnp_pkg::CH_ALPHA);
    end else begin
      cls.digit = 4'd0;
    end
    unique case (in_data.char_code)
      prnp_pkg::CH_DOLLAR, prnp_pkg::CH_LO_X: cls.pfx = prnp_pkg::PFX_HEX;
      prnp_pkg::CH_PCT, prnp_pkg::CH_LO_B:    cls.pfx = prnp_pkg::PFX_BIN;
      prnp_pkg::CH_LO_O:                      cls.pfx = prnp_pkg::PFX_OCT;
      prnp_pkg::CH_MINUS: begin
        cls.pfx = signed_mode ? prnp_pkg::PFX_NEG : prnp_pkg::PFX_NONE;
      end
      default:                                cls.pfx = prnp_pkg::PFX_NONE;
    endcase
  end

  assign in_full = (cnt_r == 2'd2);
  assign push_ok = in_push && !in_full;
  assign q_valid = (cnt_r != 2'd0);
  assign pop_ok  = q_pop && q_valid;
  assign q_head  = q_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push_ok ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop_ok ? ~rd_ptr_r : rd_ptr_r;
    cnt_nxt    = cnt_r + {1'b0, push_ok} - {1'b0, pop_ok};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push_ok) begin
      q_r[wr_ptr_r] <= cls;
    end
  end

  `PRNP_ASSERT_NOW(a_front_cnt_range, clk, rst_n, 1'b1, cnt_r <= 2'd2,
    "front queue count out of range")
  `PRNP_ASSERT_NEXT(a_front_fill, clk, rst_n, push_ok && !pop_ok,
    cnt_r == $past(cnt_r) + 2'd1, "front queue did not grow on push")

endmodule

// ----- hw/rtl/prnp_back.sv -----
// ---------------------------------------------------------------------------
// Parser back end
// Runs the prefix and Horner accumulation and holds the result register.
// ---------------------------------------------------------------------------
`include "prefixed_radix_number_parser_defines.svh"

module prnp_back #(
  parameter int unsigned VALUE_WIDTH = 32
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 q_valid,
  input  prnp_pkg::cls_t       q_head,
  output logic                 q_pop,
  output logic                 out_empty,
  output prnp_pkg::out_t       out_data,
  input  logic                 out_pop
);

  typedef enum logic {
    PH_LEAD,
    PH_BODY
  } phase_t;

  typedef enum logic [1:0] {
    RDX_2,
    RDX_8,
    RDX_10,
    RDX_16
  } radix_t;

  phase_t               phase_r, phase_nxt;
  radix_t               radix_r, radix_nxt;
  radix_t               radix_eff;
  logic                 negate_r, negate_nxt;
  logic [VALUE_WIDTH-1:0] accum_r, accum_nxt;
  logic [VALUE_WIDTH-1:0] aws_r, aws_nxt;
  logic                 bad_r, bad_nxt;
  logic                 out_valid_r, out_valid_nxt;
  prnp_pkg::out_t       out_r, out_nxt;
  logic [VALUE_WIDTH-1:0] scaled;
  logic [VALUE_WIDTH-1:0] with_digit;
  logic [VALUE_WIDTH-1:0] result;
  logic                 too_big;
  logic                 can_out;

  // Before the number starts the radix is decimal and the sum is zero.
  assign radix_eff = (phase_r == PH_LEAD) ? RDX_10 : radix_r;

  always_comb begin
    unique case (radix_eff)
      RDX_2:   scaled = aws_r << 1;
      RDX_8:   scaled = aws_r << 3;
      RDX_10:  scaled = (aws_r << 3) + (aws_r << 1);
      RDX_16:  scaled = aws_r << 4;
      default: scaled = aws_r;
    endcase
    unique case (radix_eff)
      RDX_2:   too_big = (q_head.digit > 4'd1);
      RDX_8:   too_big = (q_head.digit > 4'd7);
      RDX_10:  too_big = (q_head.digit > 4'd9);
      default: too_big = 1'b0;
    endcase
  end

  assign with_digit = scaled + VALUE_WIDTH'(q_head.digit);

  // A string end can only retire when the result register is free.
  assign can_out   = !out_valid_r || out_pop;
  assign q_pop     = q_valid && (!q_head.last || can_out);
  assign out_empty = !out_valid_r;
  assign out_data  = out_r;

  always_comb begin
    phase_nxt     = phase_r;
    radix_nxt     = radix_r;
    negate_nxt    = negate_r;
    accum_nxt     = accum_r;
    aws_nxt       = aws_r;
    bad_nxt       = bad_r;
    out_nxt       = out_r;
    out_valid_nxt = out_valid_r && !out_pop;
    result        = '0;
    if (q_pop) begin
      if (q_head.present) begin
        if (phase_r == PH_LEAD) begin
          if (!q_head.space) begin
            phase_nxt = PH_BODY;
            unique case (q_head.pfx)
              prnp_pkg::PFX_HEX: radix_nxt = RDX_16;
              prnp_pkg::PFX_BIN: radix_nxt = RDX_2;
              prnp_pkg::PFX_OCT: radix_nxt = RDX_8;
              prnp_pkg::PFX_NEG: begin
                radix_nxt  = RDX_10;
                negate_nxt = 1'b1;
              end
              default: begin
                radix_nxt = RDX_10;
                bad_nxt   = bad_r | too_big;
                aws_nxt   = with_digit;
                accum_nxt = with_digit;
              end
            endcase
          end
        end else if (q_head.space) begin
          // Inner whitespace is a zero digit that only counts if more follows.
          aws_nxt = scaled;
        end else begin
          bad_nxt   = bad_r | too_big;
          aws_nxt   = with_digit;
          accum_nxt = with_digit;
        end
      end
      if (q_head.last) begin
        if (bad_nxt) begin
          result = '0;
        end else if (negate_nxt) begin
          result = ~accum_nxt + VALUE_WIDTH'(1);
        end else begin
          result = accum_nxt;
        end
        out_nxt.value_bits = 32'(result);
        out_nxt.rejected   = bad_nxt;
        out_valid_nxt      = 1'b1;
        phase_nxt          = PH_LEAD;
        radix_nxt          = RDX_10;
        negate_nxt         = 1'b0;
        accum_nxt          = '0;
        aws_nxt            = '0;
        bad_nxt            = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_LEAD;
      radix_r     <= RDX_10;
      negate_r    <= 1'b0;
      accum_r     <= '0;
      aws_r       <= '0;
      bad_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      phase_r     <= phase_nxt;
      radix_r     <= radix_nxt;
      negate_r    <= negate_nxt;
      accum_r     <= accum_nxt;
      aws_r       <= aws_nxt;
      bad_r       <= bad_nxt;
      out_valid_r <= out_valid_nxt;
    end
    out_r <= out_nxt;
  end

  `PRNP_ASSERT_NOW(a_back_reject_zero, clk, rst_n, out_valid_r && out_r.rejected,
    out_r.value_bits == 32'd0, "rejected result carries a nonzero value")
  `PRNP_ASSERT_NEXT(a_back_string_end, clk, rst_n, q_pop && q_head.last,
    (phase_r == PH_LEAD) && !bad_r && !negate_r && out_valid_r,
    "string end did not clear state and post a result")

endmodule

// ----- hw/rtl/prefixed_radix_number_parser.sv -----
// ---------------------------------------------------------------------------
// Prefixed radix number parser
// The last character of a string is classified into the queue when it is taken;
// the back then retires it and posts the result register once that is free.
// Throughput: one character per cycle unless a string end waits on the result.
// Reset (synchronous, active low): signed_mode is 1, both queues are empty and
// the parse state returns to leading whitespace, decimal, value zero.
// ---------------------------------------------------------------------------
`include "prefixed_radix_number_parser_defines.svh"

module prefixed_radix_number_parser #(
  parameter int unsigned VALUE_WIDTH = 32
) (
  input  logic                              clk,
  input  logic                              rst_n,
  // Input channel: one character transaction per accepted push.
  input  logic                              in_push,
  output logic                              in_full,
  input  prnp_pkg::in_t                     in_data,
  // Result channel: one transaction per string.
  output logic                              out_empty,
  input  logic                              out_pop,
  output prnp_pkg::out_t                    out_data,
  // Configuration port.
  input  logic                              cfg_psel,
  input  logic                              cfg_penable,
  input  logic                              cfg_pwrite,
  input  logic [prnp_pkg::CFG_ADDR_W-1:0]   cfg_paddr,
  input  logic [31:0]                       cfg_pwdata,
  output logic [31:0]                       cfg_prdata,
  output logic                              cfg_pready
);

  // The block has one register, signed_mode, at byte address 0. Address bit 2
  // selects the register word; the two low address bits are byte offsets.
  logic           signed_mode_r, signed_mode_nxt;
  logic           cfg_write;
  logic           q_valid;
  logic           q_pop;
  prnp_pkg::cls_t q_head;

  assign cfg_pready = 1'b1;
  assign cfg_write  = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_comb begin
    signed_mode_nxt = signed_mode_r;
    if (cfg_write && (cfg_paddr[2] == prnp_pkg::REG_SIGNED_MODE)) begin
      signed_mode_nxt = cfg_pwdata[0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      signed_mode_r <= 1'b1;
    end else begin
      signed_mode_r <= signed_mode_nxt;
    end
  end

  // Reads return the register in bit 0; unused addresses read as zero.
  assign cfg_prdata = (cfg_paddr[2] == prnp_pkg::REG_SIGNED_MODE) ?
                      {31'd0, signed_mode_r} : 32'd0;

  // The front classifies each character (whitespace, digit value, prefix
  // kind) as the transaction is taken, so the back never looks at raw codes.
  prnp_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .signed_mode (signed_mode_r),
    .in_push     (in_push),
    .in_full     (in_full),
    .in_data     (in_data),
    .q_valid     (q_valid),
    .q_head      (q_head),
    .q_pop       (q_pop)
  );

  // The back drains the classify queue every cycle unless a string end meets
  // a result register that has not been popped yet.
  prnp_back #(
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_valid),
    .q_head    (q_head),
    .q_pop     (q_pop),
    .out_empty (out_empty),
    .out_data  (out_data),
    .out_pop   (out_pop)
  );

  `PRNP_ASSERT_NEXT(a_top_cfg_write, clk, rst_n,
    cfg_write && (cfg_paddr[2] == prnp_pkg::REG_SIGNED_MODE),
    signed_mode_r == $past(cfg_pwdata[0]), "signed_mode write was lost")

endmodule
